FILE: rtl/palette_nearest_color_defines.svh
// assertion helpers used by palette_nearest_color.sv
`ifndef PALETTE_NEAREST_COLOR_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define PNC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette_nearest_color: same-cycle check failed");

// next-cycle implication on clk, off during rst
`define PNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette_nearest_color: next-cycle check failed");

`endif

FILE: rtl/pnc_pkg.sv
package pnc_pkg;

  localparam int PNC_ENTRIES_DEFAULT = 256;

  localparam int CHAN_W  = 8;   // input channel width
  localparam int STORE_W = 6;   // stored channel width, low two bits dropped
  localparam int SQ_W    = 16;  // one squared channel difference
  localparam int DIST_W  = 18;  // sum of three squares, max 3*255*255

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic [STORE_W-1:0] r;
    logic [STORE_W-1:0] g;
    logic [STORE_W-1:0] b;
  } rgb6_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb8_t;

endpackage

FILE: rtl/pnc_sqdist.sv
module pnc_sqdist (
  input  logic                      clk,
  input  pnc_pkg::rgb8_t            query,
  input  pnc_pkg::rgb6_t            entry,
  output logic [pnc_pkg::DIST_W-1:0] distance
);
  import pnc_pkg::*;

  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [STORE_W-1:0] s);
    logic [CHAN_W-1:0] e;
    e = {s, 2'b00};
    return (a > e) ? (a - e) : (e - a);
  endfunction

  always_comb begin
    dr = abs_diff(query.r, entry.r);
    dg = abs_diff(query.g, entry.g);
    db = abs_diff(query.b, entry.b);
  end

  // squares registered, sum taken from the registers
  always_ff @(posedge clk) begin
    sq_r <= SQ_W'(dr) * SQ_W'(dr);
    sq_g <= SQ_W'(dg) * SQ_W'(dg);
    sq_b <= SQ_W'(db) * SQ_W'(db);
  end

  assign distance = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

endmodule

FILE: rtl/palette_nearest_color.sv
// write and unused op finish when accepted; an entry read registers the palette word,
//   then the pending result, then the output; a search stops at the first exact match
//   or after the last entry, one entry a cycle through the single palette read port
// throughput: one request at a time; next request taken while the result waits at the output
// reset: rst (sync, active high) starts a clearing pass that zeroes every palette entry,
//   no request is taken until it ends
`include "palette_nearest_color_defines.svh"

module palette_nearest_color #(
  parameter int PALETTE_ENTRIES = pnc_pkg::PNC_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]  s_tuser,   // op[1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // best_index[7:0], color_565[23:8]
);
  import pnc_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IW = (AW > CHAN_W) ? AW : CHAN_W;
  localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_EMIT
  } state_t;

  state_t state;

  // palette memory, one registered read port, one write port
  rgb6_t mem [PALETTE_ENTRIES];
  rgb6_t rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  rgb6_t wr_data;
  logic wr_en;

  // request fields
  logic [1:0]        op;
  logic [CHAN_W-1:0] entry_index;
  rgb8_t             in_color;
  logic              accept;
  logic              in_range;
  logic [AW-1:0]     in_addr;

  // clearing pass and scan control
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] issue_addr;
  logic          issue_on;
  logic          p1_valid, p2_valid;
  logic [AW-1:0] p1_idx, p2_idx;
  rgb8_t         query;
  logic          have;
  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best_idx;
  logic [DIST_W-1:0] distance;
  logic              take_new;
  logic [AW-1:0]     sel_idx;
  logic              scan_end;
  logic              rd_inrange;

  // pending result
  logic [7:0]  pend_idx;
  logic [15:0] pend_color;

  assign op          = s_tuser;
  assign entry_index = s_tdata[7:0];
  assign in_color    = '{r: s_tdata[15:8], g: s_tdata[23:16], b: s_tdata[31:24]};

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // indexes past the palette are dropped on write and read back as zero
  assign in_range = {24'd0, entry_index} < 32'(PALETTE_ENTRIES);
  assign in_addr  = AW'(IW'(entry_index));

  // write port: clearing pass or an entry write
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = accept && (op == OP_WRITE) && in_range;
      wr_addr = in_addr;
      wr_data = '{r: in_color.r[7:2], g: in_color.g[7:2], b: in_color.b[7:2]};
    end
  end

  assign rd_addr = (state == ST_SCAN) ? issue_addr : in_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // squared distance, from squares registered from the read data
  pnc_sqdist u_sqdist (
    .clk      (clk),
    .query    (query),
    .entry    (rd_data),
    .distance (distance)
  );

  // strictly smaller wins, so ties keep the lower index
  assign take_new = !have || (distance < best_d);
  assign sel_idx  = take_new ? p2_idx : best_idx;
  assign scan_end = p2_valid && ((distance == '0) || (p2_idx == LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      issue_on   <= 1'b0;
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      have       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // the emit state loads or holds the output itself
      if (m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_inrange <= in_range;
            query      <= in_color;
            case (op)
              OP_SEARCH: begin
                state      <= ST_SCAN;
                issue_addr <= '0;
                issue_on   <= 1'b1;
                have       <= 1'b0;
              end
              OP_READ: begin
                state <= ST_RDWAIT;
              end
              default: begin
                // entry write done at the port, unused op dropped
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // read issue and stage tags
          p1_idx <= issue_addr;
          p2_idx <= p1_idx;
          if (issue_on) begin
            issue_addr <= issue_addr + 1'b1;
          end
          // compare stage
          if (p2_valid) begin
            if (take_new) begin
              best_d   <= distance;
              best_idx <= p2_idx;
            end
            have <= 1'b1;
          end
          if (scan_end) begin
            // exact match or last entry: flush the reads still in flight
            state      <= ST_EMIT;
            pend_idx   <= 8'(IW'(sel_idx));
            pend_color <= '0;
            issue_on   <= 1'b0;
            p1_valid   <= 1'b0;
            p2_valid   <= 1'b0;
          end else begin
            p1_valid <= issue_on;
            p2_valid <= p1_valid;
            if (issue_on && issue_addr == LAST) begin
              issue_on <= 1'b0;
            end
          end
        end
        ST_RDWAIT: begin
          pend_idx   <= '0;
          pend_color <= rd_inrange ? {rd_data.r[5:1], rd_data.g, rd_data.b[5:1]} : 16'd0;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {pend_color, pend_idx};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // scan stages only carry data while a search runs
  `PNC_ASSERT_NOW(a_stage_in_scan, p2_valid || p1_valid, state == ST_SCAN)
  // an exact match always ends the search at once
  `PNC_ASSERT_NOW(a_zero_ends_scan, state == ST_SCAN && have, best_d != '0)
  // nothing leaves before the clearing pass is over
  `PNC_ASSERT_NOW(a_quiet_clear, state == ST_CLEAR, !m_tvalid)
  // a free output slot takes the pending result on the next edge
  `PNC_ASSERT_NEXT(a_emit_moves, state == ST_EMIT && (!m_tvalid || m_tready),
    m_tvalid && state == ST_IDLE)

endmodule
